### sv/ptl_pkg.sv
// Shared types and constants for the point-to-line projection unit.
`timescale 1ns / 1ps

package ptl_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_START_X = 3'd0;
    localparam t_cfg_idx CFG_START_Y = 3'd1;
    localparam t_cfg_idx CFG_START_Z = 3'd2;
    localparam t_cfg_idx CFG_END_X   = 3'd3;
    localparam t_cfg_idx CFG_END_Y   = 3'd4;
    localparam t_cfg_idx CFG_END_Z   = 3'd5;

    // Control that travels alongside data through a pipeline.
    typedef struct packed {
        logic vld;
        logic flag;
    } t_tag;

endpackage

### sv/ptl_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps

module ptl_div #(
    parameter int DW = 67,
    parameter int QW = 34
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ptl_pkg::t_tag   i_tag,
    input  logic [DW+QW-1:0] i_num,
    input  logic [DW-1:0]   i_den,
    output ptl_pkg::t_tag   o_tag,
    output logic [QW-1:0]   o_quo
);

    // The caller guarantees that the quotient fits in QW bits, so the upper
    // part of the dividend is already below the divisor.
    logic [DW-1:0]  r_rem [QW];
    logic [QW-1:0]  r_lq  [QW];
    ptl_pkg::t_tag  r_tag [QW];

    genvar s;
    for (s = 0; s < QW; s++) begin : g_stage
        logic [DW-1:0]  w_rem_in;
        logic [QW-1:0]  w_lq_in;
        ptl_pkg::t_tag  w_tag_in;
        logic [DW:0]    w_trial;
        logic           w_ge;
        logic [DW-1:0]  n_rem;
        logic [QW-1:0]  n_lq;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num[DW+QW-1:QW];
            assign w_lq_in  = i_num[QW-1:0];
            assign w_tag_in = i_tag;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_lq_in  = r_lq[s-1];
            assign w_tag_in = r_tag[s-1];
        end

        // The low word shifts dividend bits out at the top and quotient bits in
        // at the bottom.
        always_comb begin
            w_trial = {w_rem_in, w_lq_in[QW-1]};
            w_ge    = (w_trial >= {1'b0, i_den});
            n_rem   = w_ge ? DW'(w_trial - {1'b0, i_den}) : w_trial[DW-1:0];
            n_lq    = {w_lq_in[QW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[s].vld <= 1'b0;
            end else begin
                r_tag[s] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_lq[s]  <= n_lq;
        end
    end

    assign o_tag = r_tag[QW-1];
    assign o_quo = r_lq[QW-1];

endmodule

### sv/point_to_line_projection_3d_unit.sv
// Top level: projects a 3D point onto a configured line and returns distance.
`timescale 1ns / 1ps

// Channel   | Direction | Ports                                  | Transfer
// ----------+-----------+----------------------------------------+---------------------------
// config    | in        | i_cfg_we, i_cfg_idx, i_cfg_data        | edge with i_cfg_we high
// point     | in        | start, busy, i_point_x/y/z             | edge with start & !busy
// result    | out       | o_done, o_near_x/y/z, o_distance,      | the single o_done cycle
//           |           | o_degenerate, o_saturated              |
//
// One point enters per cycle; each result follows it through the front pipeline, the
// 2*COORD_WIDTH+4 stage distance divider, the COORD_WIDTH+2 stage square root (one
// bit per stage) and the result register. busy is high only during reset. Reset clears
// all valid bits and the line registers. The result side has no back pressure, so the
// pipeline never stalls.

module point_to_line_projection_3d_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  ptl_pkg::t_cfg_idx             i_cfg_idx,
    input  logic [COORD_WIDTH-1:0]        i_cfg_data,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_point_z,
    output logic                          o_done,
    output logic signed [COORD_WIDTH-1:0] o_near_x,
    output logic signed [COORD_WIDTH-1:0] o_near_y,
    output logic signed [COORD_WIDTH-1:0] o_near_z,
    output logic [COORD_WIDTH-1:0]        o_distance,
    output logic                          o_degenerate,
    output logic                          o_saturated
);

    localparam int W   = COORD_WIDTH;
    localparam int VW  = W + 1;          // coordinate difference
    localparam int SW  = 2 * VW;         // products and dot products
    localparam int XW  = 4 * VW;         // squared cross product
    localparam int QC  = VW + 1;         // coordinate quotient
    localparam int QD  = 2 * VW + 2;     // scaled squared distance
    localparam int RW  = VW + 1;         // square root
    localparam int DLY = QD + RW - QC;   // coordinate results wait for the distance
    localparam int LAT = 3 * W + 14;

    logic w_acc;
    assign busy  = ~i_rst_n;
    assign w_acc = start & ~busy;

    logic signed [W-1:0] w_pt [3];
    assign w_pt[0] = i_point_x;
    assign w_pt[1] = i_point_y;
    assign w_pt[2] = i_point_z;

    // ------------------------------------------------------------------
    // Line registers and values derived from them. The derived values settle through
    // registered steps after a write and are only consumed by pipeline stages that
    // an item reaches after they have settled.
    // ------------------------------------------------------------------
    logic signed [W-1:0]  r_start [3];
    logic signed [W-1:0]  r_end   [3];
    logic signed [VW-1:0] r_v     [3];
    logic [VW-1:0]        r_vabs  [3];
    logic [2:0]           r_vneg;
    logic [SW-1:0]        r_vsq   [3];
    logic [SW-1:0]        r_vv;
    logic                 r_degen;
    logic [SW-1:0]        r_vvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_start[i] <= '0;
                r_end[i]   <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ptl_pkg::CFG_START_X: r_start[0] <= i_cfg_data;
                ptl_pkg::CFG_START_Y: r_start[1] <= i_cfg_data;
                ptl_pkg::CFG_START_Z: r_start[2] <= i_cfg_data;
                ptl_pkg::CFG_END_X:   r_end[0]   <= i_cfg_data;
                ptl_pkg::CFG_END_Y:   r_end[1]   <= i_cfg_data;
                ptl_pkg::CFG_END_Z:   r_end[2]   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_v[i]    <= '0;
                r_vabs[i] <= '0;
                r_vsq[i]  <= '0;
            end
            r_vneg  <= '0;
            r_vv    <= '0;
            r_degen <= 1'b1;
            r_vvd   <= SW'(1);
        end else begin
            for (int i = 0; i < 3; i++) begin
                r_v[i]    <= VW'(r_end[i]) - VW'(r_start[i]);
                r_vabs[i] <= r_v[i][VW-1] ? VW'(-r_v[i]) : VW'(r_v[i]);
                r_vneg[i] <= r_v[i][VW-1];
                r_vsq[i]  <= r_v[i] * r_v[i];
            end
            r_vv    <= r_vsq[0] + r_vsq[1] + r_vsq[2];
            r_degen <= (r_vv == '0);
            r_vvd   <= (r_vv == '0) ? SW'(1) : r_vv;
        end
    end

    // ------------------------------------------------------------------
    // Front pipeline: offsets, products, dot and cross products.
    // ------------------------------------------------------------------
    logic [7:1] r_vld;

    logic signed [VW-1:0] r1_d   [3];
    logic signed [SW-1:0] r2_vd  [3];
    logic [SW-1:0]        r2_dd  [3];
    logic signed [SW-1:0] r2_xa  [3];
    logic signed [SW-1:0] r2_xb  [3];
    logic signed [SW+1:0] r3_dot;
    logic [SW-1:0]        r3_pp;
    logic signed [SW:0]   r3_c   [3];
    logic [SW-1:0]        r4_nm;
    logic                 r4_nsign;
    logic [SW-1:0]        r4_cm  [3];
    logic [SW-1:0]        r4_pp;
    logic [SW-1:0]        r5_nlo [3];
    logic [SW-1:0]        r5_nhi [3];
    logic [SW-1:0]        r5_chh [3];
    logic [SW-1:0]        r5_chl [3];
    logic [SW-1:0]        r5_cll [3];
    logic [SW-1:0]        r5_pp;
    logic                 r5_nsign;
    logic [3*VW-1:0]      r6_num [3];
    logic [XW-1:0]        r6_csq [3];
    logic [SW-1:0]        r6_pp;
    logic                 r6_nsign;
    logic [3*VW+1:0]      r7_cn  [3];
    logic [2:0]           r7_neg;
    logic [XW+1:0]        r7_y;
    logic                 r7_degen;
    logic [XW-1:0]        w_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:1], w_acc};
        end
    end

    // Squared distance times |v|^2 equals |v x d|^2; split squares keep every multiplier
    // operand within the width of one coordinate difference. A degenerate line uses |d|^2.
    assign w_x = r_degen ? XW'(r6_pp) : r6_csq[0] + r6_csq[1] + r6_csq[2];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (w_acc) begin
                r1_d[i] <= VW'(w_pt[i]) - VW'(r_start[i]);
            end
            r2_vd[i] <= r_v[i] * r1_d[i];
            r2_dd[i] <= r1_d[i] * r1_d[i];
            r3_c[i]  <= (SW+1)'(r2_xa[i]) - (SW+1)'(r2_xb[i]);
            r4_cm[i] <= r3_c[i][SW] ? SW'(-r3_c[i]) : SW'(r3_c[i]);
            r5_nlo[i] <= r_vabs[i] * r4_nm[VW-1:0];
            r5_nhi[i] <= r_vabs[i] * r4_nm[SW-1:VW];
            r5_chh[i] <= r4_cm[i][SW-1:VW] * r4_cm[i][SW-1:VW];
            r5_chl[i] <= r4_cm[i][SW-1:VW] * r4_cm[i][VW-1:0];
            r5_cll[i] <= r4_cm[i][VW-1:0] * r4_cm[i][VW-1:0];
            r6_num[i] <= {r5_nhi[i], {VW{1'b0}}} + (3*VW)'(r5_nlo[i]);
            r6_csq[i] <= {r5_chh[i], {SW{1'b0}}}
                       + XW'({r5_chl[i], {(VW+1){1'b0}}})
                       + XW'(r5_cll[i]);
            r7_cn[i]  <= {r6_num[i], 1'b0} + (3*VW+2)'(r_vvd);
            r7_neg[i] <= r_vneg[i] ^ r6_nsign;
        end
        r3_dot   <= (SW+2)'(r2_vd[0]) + (SW+2)'(r2_vd[1]) + (SW+2)'(r2_vd[2]);
        r3_pp    <= r2_dd[0] + r2_dd[1] + r2_dd[2];
        r4_nm    <= r3_dot[SW+1] ? SW'(-r3_dot) : SW'(r3_dot);
        r4_nsign <= r3_dot[SW+1];
        r4_pp    <= r3_pp;
        r5_pp    <= r4_pp;
        r5_nsign <= r4_nsign;
        r6_pp    <= r5_pp;
        r6_nsign <= r5_nsign;
        r7_y     <= {w_x, 2'b00};
        r7_degen <= r_degen;
    end

    genvar i;
    for (i = 0; i < 3; i++) begin : g_cross
        localparam int J1 = (i + 1) % 3;
        localparam int J2 = (i + 2) % 3;
        always_ff @(posedge i_clk) begin
            r2_xa[i] <= r_v[J1] * r1_d[J2];
            r2_xb[i] <= r_v[J2] * r1_d[J1];
        end
    end

    // ------------------------------------------------------------------
    // Closest point: offset_i = round(|v_i| * |dot| / |v|^2), ties away from zero.
    // ------------------------------------------------------------------
    ptl_pkg::t_tag      w_ctag_in [3];
    ptl_pkg::t_tag      w_ctag    [3];
    logic [QC-1:0]      w_cq      [3];
    logic signed [W+2:0] w_off    [3];
    logic signed [W+2:0] w_sum    [3];
    logic [W-1:0]       w_near    [3];
    logic [2:0]         w_csat;
    logic               w_cvld;

    for (i = 0; i < 3; i++) begin : g_coord
        assign w_ctag_in[i] = '{vld: r_vld[7], flag: r7_neg[i]};

        ptl_div #(
            .DW (SW + 1),
            .QW (QC)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_tag   (w_ctag_in[i]),
            .i_num   (r7_cn[i]),
            .i_den   ({r_vvd, 1'b0}),
            .o_tag   (w_ctag[i]),
            .o_quo   (w_cq[i])
        );

        always_comb begin
            w_off[i] = w_ctag[i].flag ? -$signed({1'b0, w_cq[i]}) : $signed({1'b0, w_cq[i]});
            w_sum[i] = (W+3)'(r_start[i]) + w_off[i];
            w_csat[i] = !((w_sum[i][W+2:W-1] == '0) || (w_sum[i][W+2:W-1] == '1));
            if (!w_csat[i]) begin
                w_near[i] = w_sum[i][W-1:0];
            end else if (w_sum[i][W+2]) begin
                w_near[i] = {1'b1, {(W-1){1'b0}}};
            end else begin
                w_near[i] = {1'b0, {(W-1){1'b1}}};
            end
        end
    end

    assign w_cvld = w_ctag[0].vld & w_ctag[1].vld & w_ctag[2].vld;

    // Coordinate results wait here until the distance for the same item is done.
    logic [W-1:0]   r_dl_near [DLY][3];
    logic [DLY-1:0] r_dl_sat;
    logic [DLY-1:0] r_dl_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_vld <= '0;
        end else begin
            r_dl_vld <= {r_dl_vld[DLY-2:0], w_cvld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl_near[0] <= w_near;
        for (int k = 1; k < DLY; k++) begin
            r_dl_near[k] <= r_dl_near[k-1];
        end
        r_dl_sat <= {r_dl_sat[DLY-2:0], |w_csat};
    end

    // ------------------------------------------------------------------
    // Distance: y = floor(4 * |v x d|^2 / |v|^2), then floor(sqrt(y)), halved
    // with rounding.
    // ------------------------------------------------------------------
    ptl_pkg::t_tag w_dtag_in;
    ptl_pkg::t_tag w_dtag;
    logic [QD-1:0] w_y;

    assign w_dtag_in = '{vld: r_vld[7], flag: r7_degen};

    ptl_div #(
        .DW (SW),
        .QW (QD)
    ) u_dist_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_dtag_in),
        .i_num   (r7_y),
        .i_den   (r_vvd),
        .o_tag   (w_dtag),
        .o_quo   (w_y)
    );

    logic [RW:0]   r_sq_rem  [RW];
    logic [RW-1:0] r_sq_root [RW];
    logic [QD-1:0] r_sq_y    [RW];
    ptl_pkg::t_tag r_sq_tag  [RW];

    genvar s;
    for (s = 0; s < RW; s++) begin : g_sqrt
        logic [RW:0]   w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [QD-1:0] w_y_in;
        ptl_pkg::t_tag w_tag_in;
        logic [RW+2:0] w_t;
        logic [RW+2:0] w_trial;
        logic          w_ge;
        logic [RW:0]   n_rem;
        logic [RW-1:0] n_root;

        if (s == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_y_in    = w_y;
            assign w_tag_in  = w_dtag;
        end else begin : g_next
            assign w_rem_in  = r_sq_rem[s-1];
            assign w_root_in = r_sq_root[s-1];
            assign w_y_in    = r_sq_y[s-1];
            assign w_tag_in  = r_sq_tag[s-1];
        end

        always_comb begin
            w_t     = {w_rem_in, w_y_in[QD-1:QD-2]};
            w_trial = {1'b0, w_root_in, 2'b01};
            w_ge    = (w_t >= w_trial);
            n_rem   = w_ge ? (RW+1)'(w_t - w_trial) : w_t[RW:0];
            n_root  = {w_root_in[RW-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_tag[s].vld <= 1'b0;
            end else begin
                r_sq_tag[s] <= w_tag_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_rem[s]  <= n_rem;
            r_sq_root[s] <= n_root;
            r_sq_y[s]    <= {w_y_in[QD-3:0], 2'b00};
        end
    end

    logic [RW:0]   w_dsum;
    logic [RW-1:0] w_dist;
    logic          w_dsat;

    assign w_dsum = {1'b0, r_sq_root[RW-1]} + (RW+1)'(1);
    assign w_dist = w_dsum[RW:1];
    assign w_dsat = |w_dist[RW-1:W];

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic         r_done;
    logic [W-1:0] r_out_near [3];
    logic [W-1:0] r_out_dist;
    logic         r_out_degen;
    logic         r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_sq_tag[RW-1].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_near  <= r_dl_near[DLY-1];
        r_out_dist  <= w_dsat ? '1 : w_dist[W-1:0];
        r_out_degen <= r_sq_tag[RW-1].flag;
        r_out_sat   <= r_dl_sat[DLY-1] | w_dsat;
    end

    assign o_done       = r_done;
    assign o_near_x     = r_out_near[0];
    assign o_near_y     = r_out_near[1];
    assign o_near_z     = r_out_near[2];
    assign o_distance   = r_out_dist;
    assign o_degenerate = r_out_degen;
    assign o_saturated  = r_out_sat;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted point did not produce a result after the pipeline latency");

    a_paths_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dl_vld[DLY-1] == r_sq_tag[RW-1].vld)
        else $error("coordinate and distance paths out of step");

    a_degen_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |->
            (o_near_x == r_start[0] && o_near_y == r_start[1] && o_near_z == r_start[2]))
        else $error("degenerate line did not return the first endpoint");

endmodule
